// File: hdl/ppjs_pkg.sv
package ppjs_pkg;

  localparam int DATA_W    = 32;
  localparam int GW_W      = 7;
  localparam int GH_W      = 11;
  localparam int COEF_XY_W = 16;
  localparam int COEF_B_W  = 32;
  localparam int CHG_W     = 47;
  localparam int PSUM_W    = 48;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B      = 3'd4;

  localparam logic [GW_W-1:0]      GRID_WIDTH_RST  = 7'd64;
  localparam logic [GH_W-1:0]      GRID_HEIGHT_RST = 11'd64;
  localparam logic [COEF_XY_W-1:0] COEF_X_RST      = 16'd16384;
  localparam logic [COEF_XY_W-1:0] COEF_Y_RST      = 16'd16384;
  localparam logic [COEF_B_W-1:0]  COEF_B_RST      = 32'd0;

  localparam logic [DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

  typedef struct packed {
    logic done;
    logic restart;
  } ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] pl;
    logic [DATA_W-1:0] pr;
    logic [DATA_W-1:0] pu;
    logic [DATA_W-1:0] pd;
    logic [DATA_W-1:0] pc;
    logic [DATA_W-1:0] bv;
  } tap_t;

endpackage

// File: hdl/pressure_poisson_jacobi_sweep.sv
// One Jacobi sweep of a 5-point pressure Poisson stencil over a grid streamed in raster order,
// one cell per beat, at a sustained rate of one cell per clock cycle when not stalled. The
// result for interior cell (r-1, c-1) is output once cell (r, c) has passed the pipeline
// registers; boundary cells give no result. The rate is set by the pressure line buffer, held
// as two copies of a 2^ceil(log2(2*MAX_WIDTH+1)) x 32 memory with two read ports each, plus a
// MAX_WIDTH x 32 source buffer, so every stencil is read in the cycle its last cell arrives.
// The multiply, round and accumulate steps run in a stalling pipeline that keeps taking cells
// while a finished result waits, until it is full. change_sum and pressure_sum are running,
// saturating sums cleared at each new frame and valid as frame totals where frame_done is set.
// Write the registers only while no result is outstanding.
module pressure_poisson_jacobi_sweep import ppjs_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_B_W-1:0]           cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_W-1:0]      old_pressure,
  input  logic signed [DATA_W-1:0]      source_term,
  input  logic                          start_of_frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [$clog2(MAX_WIDTH)-1:0]  cell_column,
  output logic [$clog2(MAX_HEIGHT)-1:0] cell_row,
  output logic signed [DATA_W-1:0]      new_pressure,
  output logic [CHG_W-1:0]              change_sum,
  output logic signed [PSUM_W-1:0]      pressure_sum,
  output logic                          frame_done
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [GW_W-1:0]      grid_width;
  logic [GH_W-1:0]      grid_height;
  logic [COEF_XY_W-1:0] coef_x;
  logic [COEF_XY_W-1:0] coef_y;
  logic [COEF_B_W-1:0]  coef_b;

  logic             s1_valid, s1_take;
  tap_t             tap;
  logic [COL_W-1:0] s1_col, res_col;
  logic [ROW_W-1:0] s1_row, res_row;
  ctl_t             s1_ctl, res_ctl;
  logic             res_valid, res_take;
  logic [DATA_W-1:0] res_np, res_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      coef_x      <= COEF_X_RST;
      coef_y      <= COEF_Y_RST;
      coef_b      <= COEF_B_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[GW_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[GH_W-1:0];
        REG_COEF_X:      coef_x      <= cfg_data[COEF_XY_W-1:0];
        REG_COEF_Y:      coef_y      <= cfg_data[COEF_XY_W-1:0];
        REG_COEF_B:      coef_b      <= cfg_data[COEF_B_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ppjs_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .old_pressure   (old_pressure),
    .source_term    (source_term),
    .start_of_frame (start_of_frame),
    .grid_width     (grid_width),
    .grid_height    (grid_height),
    .s1_take        (s1_take),
    .s1_valid       (s1_valid),
    .tap            (tap),
    .col            (s1_col),
    .row            (s1_row),
    .ctl            (s1_ctl)
  );

  ppjs_pipe #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .coef_x    (coef_x),
    .coef_y    (coef_y),
    .coef_b    (coef_b),
    .s1_valid  (s1_valid),
    .s1_take   (s1_take),
    .tap       (tap),
    .col_in    (s1_col),
    .row_in    (s1_row),
    .ctl_in    (s1_ctl),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_np    (res_np),
    .res_d     (res_d),
    .res_col   (res_col),
    .res_row   (res_row),
    .res_ctl   (res_ctl)
  );

  ppjs_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res_np       (res_np),
    .res_d        (res_d),
    .res_col      (res_col),
    .res_row      (res_row),
    .res_ctl      (res_ctl),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_column  (cell_column),
    .cell_row     (cell_row),
    .new_pressure (new_pressure),
    .change_sum   (change_sum),
    .pressure_sum (pressure_sum),
    .frame_done   (frame_done)
  );

endmodule

// File: hdl/ppjs_window.sv
module ppjs_window import ppjs_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_W-1:0]      old_pressure,
  input  logic signed [DATA_W-1:0]      source_term,
  input  logic                          start_of_frame,
  input  logic [GW_W-1:0]               grid_width,
  input  logic [GH_W-1:0]               grid_height,
  input  logic                          s1_take,
  output logic                          s1_valid,
  output tap_t                          tap,
  output logic [$clog2(MAX_WIDTH)-1:0]  col,
  output logic [$clog2(MAX_HEIGHT)-1:0] row,
  output ctl_t                          ctl
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int AW       = $clog2(2 * MAX_WIDTH + 2);
  localparam int HW       = $clog2(MAX_HEIGHT + 1);
  localparam int PTR_W    = $clog2(2 * MAX_WIDTH + 1);
  localparam int DEPTH    = 1 << PTR_W;
  localparam int FILL_MAX = 2 * MAX_WIDTH + 1;

  logic [DATA_W-1:0] pmem_a [DEPTH];
  logic [DATA_W-1:0] pmem_b [DEPTH];
  logic [DATA_W-1:0] src_mem [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] src_vld;

  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [PTR_W-1:0] wp;
  logic [AW-1:0]    fill;
  logic [DATA_W-1:0] last_p;
  logic [DATA_W-1:0] src_hold;
  logic              src_hold_vld;
  logic              pend;

  logic [DATA_W-1:0] pr_q, pc_q, pl_q, pu_q, pd_q, bv_q;
  logic              vr, vc, vl, vu;

  logic              accept;
  logic [AW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic [COL_W-1:0]  c, c_next;
  logic [ROW_W-1:0]  r, r_next;
  logic [AW-1:0]     c_ext;
  logic [HW-1:0]     r_ext, r_inc;
  logic              col_wrap, produce, done, first;
  logic [AW-1:0]     age_r, age_c, age_l, age_u;
  logic [PTR_W-1:0]  addr_r, addr_c, addr_l, addr_u;

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_valid || s1_take;

  always_comb begin
    if (grid_width < GW_W'(3)) begin
      w_eff = AW'(3);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = AW'(MAX_WIDTH);
    end else begin
      w_eff = AW'(grid_width);
    end
    if (grid_height < GH_W'(3)) begin
      h_eff = HW'(3);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(grid_height);
    end
  end

  always_comb begin
    c        = start_of_frame ? '0 : col_cnt;
    r        = start_of_frame ? '0 : row_cnt;
    c_ext    = AW'(c);
    r_ext    = HW'(r);
    r_inc    = r_ext + HW'(1);
    first    = (c == '0) && (r == '0);
    produce  = (c >= COL_W'(2)) && (r >= ROW_W'(2));
    done     = (r_ext == h_eff - HW'(1)) && (c_ext == w_eff - AW'(1));
    col_wrap = (c_ext + AW'(1)) >= w_eff;
    if (col_wrap) begin
      c_next = '0;
      r_next = (r_inc >= h_eff) ? '0 : ROW_W'(r_inc);
    end else begin
      c_next = COL_W'(c_ext + AW'(1));
      r_next = (r_ext >= h_eff) ? '0 : r;
    end
  end

  always_comb begin
    age_r  = w_eff;
    age_c  = w_eff + AW'(1);
    age_l  = w_eff + AW'(2);
    age_u  = (w_eff << 1) + AW'(1);
    addr_r = wp - PTR_W'(age_r);
    addr_c = wp - PTR_W'(age_c);
    addr_l = wp - PTR_W'(age_l);
    addr_u = wp - PTR_W'(age_u);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pmem_a[wp] <= old_pressure;
      pr_q       <= pmem_a[addr_r];
      pc_q       <= pmem_a[addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pmem_b[wp] <= old_pressure;
      pl_q       <= pmem_b[addr_l];
      pu_q       <= pmem_b[addr_u];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_hold   <= src_mem[c];
      src_mem[c] <= source_term;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vr       <= fill >= age_r;
      vc       <= fill >= age_c;
      vl       <= fill >= age_l;
      vu       <= fill >= age_u;
      pd_q     <= last_p;
      bv_q     <= src_hold_vld ? src_hold : '0;
      col      <= c - COL_W'(1);
      row      <= r - ROW_W'(1);
      ctl.done    <= done;
      ctl.restart <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt      <= '0;
      row_cnt      <= '0;
      wp           <= '0;
      fill         <= '0;
      last_p       <= '0;
      src_vld      <= '0;
      src_hold_vld <= 1'b0;
      pend         <= 1'b0;
      s1_valid     <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid && produce;
      end
      if (accept) begin
        col_cnt      <= c_next;
        row_cnt      <= r_next;
        wp           <= wp + PTR_W'(1);
        fill         <= (fill == AW'(FILL_MAX)) ? fill : fill + AW'(1);
        last_p       <= old_pressure;
        src_hold_vld <= src_vld[c];
        src_vld[c]   <= 1'b1;
        if (first) begin
          pend <= 1'b1;
        end else if (produce) begin
          pend <= 1'b0;
        end
      end
    end
  end

  assign tap.pr = vr ? pr_q : '0;
  assign tap.pc = vc ? pc_q : '0;
  assign tap.pl = vl ? pl_q : '0;
  assign tap.pu = vu ? pu_q : '0;
  assign tap.pd = pd_q;
  assign tap.bv = bv_q;

endmodule

// File: hdl/ppjs_pipe.sv
module ppjs_pipe import ppjs_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [COEF_XY_W-1:0]          coef_x,
  input  logic [COEF_XY_W-1:0]          coef_y,
  input  logic [COEF_B_W-1:0]           coef_b,
  input  logic                          s1_valid,
  output logic                          s1_take,
  input  tap_t                          tap,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col_in,
  input  logic [$clog2(MAX_HEIGHT)-1:0] row_in,
  input  ctl_t                          ctl_in,
  output logic                          res_valid,
  input  logic                          res_take,
  output logic [DATA_W-1:0]             res_np,
  output logic [DATA_W-1:0]             res_d,
  output logic [$clog2(MAX_WIDTH)-1:0]  res_col,
  output logic [$clog2(MAX_HEIGHT)-1:0] res_row,
  output ctl_t                          res_ctl
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int X_W   = DATA_W + 1 + COEF_XY_W + 1;
  localparam int B_W   = DATA_W + COEF_B_W + 1;
  localparam int T_W   = B_W + 2;

  localparam logic signed [T_W-1:0] RND   = T_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [T_W-1:0] Q_MAX = T_W'(32'sh7FFF_FFFF);
  localparam logic signed [T_W-1:0] Q_MIN = T_W'(32'sh8000_0000);

  logic v2, v3, v4, v5;
  logic rdy2, rdy3, rdy4, rdy5;

  logic signed [DATA_W:0]   sx2, sy2;
  logic signed [DATA_W-1:0] bv2;
  logic [DATA_W-1:0]        pc2, pc3, pc4;
  logic signed [X_W-1:0]    px3, py3;
  logic signed [B_W-1:0]    pb3;
  logic [DATA_W-1:0]        np4;
  logic [COL_W-1:0]         col2, col3, col4;
  logic [ROW_W-1:0]         row2, row3, row4;
  ctl_t                     ctl2, ctl3, ctl4;

  logic signed [T_W-1:0]    t4, q4;
  logic signed [DATA_W:0]   diff5;

  assign rdy5    = !v5 || res_take;
  assign rdy4    = !v4 || rdy5;
  assign rdy3    = !v3 || rdy4;
  assign rdy2    = !v2 || rdy3;
  assign s1_take = rdy2;
  assign res_valid = v5;

  always_comb begin
    t4 = T_W'(px3) + T_W'(py3) - T_W'(pb3) + RND;
    q4 = t4 >>> FRAC_BITS;
    diff5 = $signed({np4[DATA_W-1], np4}) - $signed({pc4[DATA_W-1], pc4});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy2) v2 <= s1_valid;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sx2  <= $signed({tap.pl[DATA_W-1], tap.pl}) + $signed({tap.pr[DATA_W-1], tap.pr});
      sy2  <= $signed({tap.pu[DATA_W-1], tap.pu}) + $signed({tap.pd[DATA_W-1], tap.pd});
      bv2  <= $signed(tap.bv);
      pc2  <= tap.pc;
      col2 <= col_in;
      row2 <= row_in;
      ctl2 <= ctl_in;
    end
    if (rdy3) begin
      px3  <= $signed({1'b0, coef_x}) * sx2;
      py3  <= $signed({1'b0, coef_y}) * sy2;
      pb3  <= $signed({1'b0, coef_b}) * bv2;
      pc3  <= pc2;
      col3 <= col2;
      row3 <= row2;
      ctl3 <= ctl2;
    end
    if (rdy4) begin
      if (q4 > Q_MAX) begin
        np4 <= DATA_MAX;
      end else if (q4 < Q_MIN) begin
        np4 <= DATA_MIN;
      end else begin
        np4 <= q4[DATA_W-1:0];
      end
      pc4  <= pc3;
      col4 <= col3;
      row4 <= row3;
      ctl4 <= ctl3;
    end
    if (rdy5) begin
      res_np  <= np4;
      res_d   <= diff5[DATA_W] ? DATA_W'(-diff5) : diff5[DATA_W-1:0];
      res_col <= col4;
      res_row <= row4;
      res_ctl <= ctl4;
    end
  end

endmodule

// File: hdl/ppjs_accum.sv
module ppjs_accum import ppjs_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          res_valid,
  output logic                          res_take,
  input  logic [DATA_W-1:0]             res_np,
  input  logic [DATA_W-1:0]             res_d,
  input  logic [$clog2(MAX_WIDTH)-1:0]  res_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0] res_row,
  input  ctl_t                          res_ctl,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [$clog2(MAX_WIDTH)-1:0]  cell_column,
  output logic [$clog2(MAX_HEIGHT)-1:0] cell_row,
  output logic signed [DATA_W-1:0]      new_pressure,
  output logic [CHG_W-1:0]              change_sum,
  output logic signed [PSUM_W-1:0]      pressure_sum,
  output logic                          frame_done
);

  logic [CHG_W-1:0]  chg_base, chg_next;
  logic [CHG_W:0]    chg_sum;
  logic [PSUM_W-1:0] ps_base, ps_next;
  logic [PSUM_W:0]   ps_sum;

  assign res_take = !out_valid || out_ready;

  always_comb begin
    chg_base = res_ctl.restart ? '0 : change_sum;
    chg_sum  = {1'b0, chg_base} + (CHG_W + 1)'(res_d);
    chg_next = chg_sum[CHG_W] ? {CHG_W{1'b1}} : chg_sum[CHG_W-1:0];
    ps_base  = res_ctl.restart ? '0 : pressure_sum;
    ps_sum   = {ps_base[PSUM_W-1], ps_base}
             + {{(PSUM_W + 1 - DATA_W){res_np[DATA_W-1]}}, res_np};
    if (ps_sum[PSUM_W] != ps_sum[PSUM_W-1]) begin
      ps_next = ps_sum[PSUM_W] ? {1'b1, {(PSUM_W-1){1'b0}}} : {1'b0, {(PSUM_W-1){1'b1}}};
    end else begin
      ps_next = ps_sum[PSUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      change_sum   <= '0;
      pressure_sum <= '0;
    end else if (res_take) begin
      out_valid <= res_valid;
      if (res_valid) begin
        change_sum   <= chg_next;
        pressure_sum <= ps_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      cell_column  <= res_col;
      cell_row     <= res_row;
      new_pressure <= res_np;
      frame_done   <= res_ctl.done;
    end
  end

endmodule

// File: hdl/ppjs_checker.sv
module ppjs_checker import ppjs_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [$clog2(MAX_WIDTH)-1:0]  cell_column,
  input logic [$clog2(MAX_HEIGHT)-1:0] cell_row,
  input logic signed [DATA_W-1:0]      new_pressure,
  input logic [CHG_W-1:0]              change_sum,
  input logic                          frame_done
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_pressure) && $stable(change_sum))
    else $error("result beat changed while stalled");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused while result side is free");

  a_next_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && frame_done) ##1 out_valid
      |-> cell_column == COL_W'(1) && cell_row == ROW_W'(1))
    else $error("result after frame end is not the first interior cell");

  a_sum_grows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready)
      ##1 (out_valid && !(cell_column == COL_W'(1) && cell_row == ROW_W'(1)))
      |-> change_sum >= $past(change_sum))
    else $error("change sum dropped within a frame");

endmodule

bind pressure_poisson_jacobi_sweep ppjs_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT)
) u_checker (.*);
